[rtl/core/bks_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bks_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 32;
    localparam int STEER_W     = 24;
    localparam int SPEED_W     = 24;
    localparam int DT_W        = 20;
    localparam int PHASE_W     = 32;
    localparam int CORDIC_W    = 33;
    localparam int ATAN_COUNT  = 30;
    localparam int VDT_W       = 28;
    localparam int NUM_W       = VDT_W + CORDIC_W;
    localparam int DEN_W       = 42;
    localparam int QUO_W       = 34;
    localparam int CMP_W       = DEN_W + QUO_W;
    localparam int DYAW_W      = QUO_W + 2;
    localparam int WIDE_W      = DYAW_W + 1;
    localparam int WB_W        = 24;
    localparam int SLIM_W      = 17;
    localparam int VLIM_W      = 23;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 96;

    localparam logic signed [30:0]         INV_TWO_PI  = 31'sd683565276;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [WB_W-1:0]   WHEELBASE_RST = 24'd176947;
    localparam logic [SLIM_W-1:0] STEER_LIM_RST = 17'd39322;
    localparam logic [VLIM_W-1:0] FWD_LIM_RST   = 23'd131072;
    localparam logic [VLIM_W-1:0] REV_LIM_RST   = 23'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEELBASE   = 8'd0,
        REG_STEER_LIMIT = 8'd1,
        REG_FWD_LIMIT   = 8'd2,
        REG_REV_LIMIT   = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] hd;
        logic signed [VDT_W-1:0] vdt;
    } pose_t;

    typedef struct packed {
        logic [POS_W-1:0]        nx;
        logic [POS_W-1:0]        ny;
        logic signed [POS_W-1:0] hd;
        logic                    sat;
        logic                    neg;
        logic                    ovf;
    } div_side_t;

    function automatic logic [29:0] atan_phase(input int i);
        logic [29:0] r;
        case (i)
            0:  r = 30'd536870912;
            1:  r = 30'd316933406;
            2:  r = 30'd167458907;
            3:  r = 30'd85004756;
            4:  r = 30'd42667331;
            5:  r = 30'd21354465;
            6:  r = 30'd10679838;
            7:  r = 30'd5339989;
            8:  r = 30'd2670035;
            9:  r = 30'd1335087;
            10: r = 30'd667544;
            11: r = 30'd333772;
            12: r = 30'd166886;
            13: r = 30'd83443;
            14: r = 30'd41722;
            15: r = 30'd20861;
            16: r = 30'd10430;
            17: r = 30'd5215;
            18: r = 30'd2608;
            19: r = 30'd1304;
            20: r = 30'd652;
            21: r = 30'd326;
            22: r = 30'd163;
            23: r = 30'd81;
            24: r = 30'd41;
            25: r = 30'd20;
            26: r = 30'd10;
            27: r = 30'd5;
            28: r = 30'd3;
            29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // clip to 32 bits; bit 32 flags a clip
    function automatic logic [POS_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [POS_W:0] r;
        if (v > WIDE_W'(signed'(33'sd2147483647)))
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < WIDE_W'(signed'(-33'sd2147483648)))
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[POS_W-1:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bicycle_kinematic_step_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Kinematic bicycle pose update, one Euler step per item.
// Input stream s_axis_*: one pose plus steering, speed and time step per item.
// Output stream m_axis_*: next pose in tdata, clip flag in tuser.
// Config channel cfg_*: register index and data, always ready; write only
// while no item is in flight.
// Pipeline: unpack and clamp, phase products, the CORDIC iteration stages,
// products, position sums, the 34-stage restoring divider for the heading
// rate, then the output register.
// Throughput: one item per cycle while the output is not stalled; every stage advances together.
// Receiver stall: when the output register holds an item and m_axis_tready
// is low, the whole pipeline holds and s_axis_tready drops; nothing is lost.
// Reset: valid bits clear, config registers load their default values.

module bicycle_kinematic_step_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pos_x, pos_y, heading, steer_cmd, speed_cmd, time_step, zero fill
    input  wire  [bks_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // next_x, next_y, next_heading
    output logic [bks_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // saturated
    output logic                                  m_axis_tuser,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [bks_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [bks_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int PW  = bks_pkg::POS_W;
    localparam int CW  = bks_pkg::CORDIC_W;
    localparam int FB  = bks_pkg::FRAC_BITS;
    localparam int NW  = bks_pkg::NUM_W;
    localparam int DW  = bks_pkg::DEN_W;
    localparam int QW  = bks_pkg::QUO_W;
    localparam int VW  = bks_pkg::VDT_W;
    localparam int XW  = bks_pkg::WIDE_W;

    logic [bks_pkg::WB_W-1:0]   wheelbase_reg;
    logic [bks_pkg::SLIM_W-1:0] steer_lim_reg;
    logic [bks_pkg::VLIM_W-1:0] fwd_lim_reg;
    logic [bks_pkg::VLIM_W-1:0] rev_lim_reg;

    logic adv;
    logic out_vld_reg;

    assign cfg_ready     = 1'b1;
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg <= bks_pkg::WHEELBASE_RST;
            steer_lim_reg <= bks_pkg::STEER_LIM_RST;
            fwd_lim_reg   <= bks_pkg::FWD_LIM_RST;
            rev_lim_reg   <= bks_pkg::REV_LIM_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bks_pkg::REG_WHEELBASE:   wheelbase_reg <= cfg_data[bks_pkg::WB_W-1:0];
                bks_pkg::REG_STEER_LIMIT: steer_lim_reg <= cfg_data[bks_pkg::SLIM_W-1:0];
                bks_pkg::REG_FWD_LIMIT:   fwd_lim_reg   <= cfg_data[bks_pkg::VLIM_W-1:0];
                bks_pkg::REG_REV_LIMIT:   rev_lim_reg   <= cfg_data[bks_pkg::VLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: unpack and clamp
    logic signed [PW-1:0] in_px;
    logic signed [PW-1:0] in_py;
    logic signed [PW-1:0] in_hd;
    logic signed [23:0]   in_delta;
    logic signed [23:0]   in_v;
    logic [19:0]          in_dt;
    logic signed [23:0]   slim;
    logic signed [23:0]   fwd;
    logic signed [23:0]   rev;
    logic signed [23:0]   delta_next;
    logic signed [23:0]   v_next;

    assign in_px    = signed'(s_axis_tdata[31:0]);
    assign in_py    = signed'(s_axis_tdata[63:32]);
    assign in_hd    = signed'(s_axis_tdata[95:64]);
    assign in_delta = signed'(s_axis_tdata[119:96]);
    assign in_v     = signed'(s_axis_tdata[143:120]);
    assign in_dt    = s_axis_tdata[163:144];
    assign slim     = signed'({7'b0, steer_lim_reg});
    assign fwd      = signed'({1'b0, fwd_lim_reg});
    assign rev      = signed'({1'b0, rev_lim_reg});

    always_comb
    begin
        delta_next = in_delta;
        if (in_delta > slim)
            delta_next = slim;
        else if (in_delta < -slim)
            delta_next = -slim;
        v_next = in_v;
        if (!in_v[23])
        begin
            if (in_v > fwd)
                v_next = fwd;
        end
        else if (in_v < -rev)
        begin
            v_next = -rev;
        end
    end

    logic                 s1_vld_reg;
    logic signed [PW-1:0] s1_px_reg;
    logic signed [PW-1:0] s1_py_reg;
    logic signed [PW-1:0] s1_hd_reg;
    logic signed [23:0]   s1_delta_reg;
    logic signed [23:0]   s1_v_reg;
    logic [19:0]          s1_dt_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= in_px;
            s1_py_reg    <= in_py;
            s1_hd_reg    <= in_hd;
            s1_delta_reg <= delta_next;
            s1_v_reg     <= v_next;
            s1_dt_reg    <= in_dt;
        end
    end

    // stage 2: distance step and angle-to-phase products
    logic signed [44:0] vdt_prod;
    logic signed [62:0] ph_h_prod;
    logic signed [54:0] ph_d_prod;

    assign vdt_prod  = s1_v_reg * signed'({1'b0, s1_dt_reg});
    assign ph_h_prod = s1_hd_reg * bks_pkg::INV_TWO_PI;
    assign ph_d_prod = s1_delta_reg * bks_pkg::INV_TWO_PI;

    logic                          s2_vld_reg;
    bks_pkg::pose_t                s2_pose_reg;
    logic [bks_pkg::PHASE_W-1:0]   s2_ph_h_reg;
    logic [bks_pkg::PHASE_W-1:0]   s2_ph_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pose_reg.px  <= s1_px_reg;
            s2_pose_reg.py  <= s1_py_reg;
            s2_pose_reg.hd  <= s1_hd_reg;
            s2_pose_reg.vdt <= vdt_prod[VW+FB-1:FB];
            s2_ph_h_reg     <= ph_h_prod[FB+31:FB];
            s2_ph_d_reg     <= ph_d_prod[FB+31:FB];
        end
    end

    logic                 c_vld;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] cd;
    logic signed [CW-1:0] sd;
    bks_pkg::pose_t       c_pose;

    bks_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_vld_reg),
        .phase_a   (s2_ph_h_reg),
        .phase_b   (s2_ph_d_reg),
        .side_in   (s2_pose_reg),
        .out_valid (c_vld),
        .cos_a     (cy),
        .sin_a     (sy),
        .cos_b     (cd),
        .sin_b     (sd),
        .side_out  (c_pose)
    );

    // stage M: products
    logic signed [NW-1:0] dx_prod;
    logic signed [NW-1:0] dy_prod;
    logic signed [NW-1:0] num_prod;
    logic signed [57:0]   den_prod;

    assign dx_prod  = c_pose.vdt * cy;
    assign dy_prod  = c_pose.vdt * sy;
    assign num_prod = c_pose.vdt * sd;
    assign den_prod = cd * signed'({1'b0, wheelbase_reg});

    logic                 m_vld_reg;
    logic signed [PW-1:0] m_px_reg;
    logic signed [PW-1:0] m_py_reg;
    logic signed [PW-1:0] m_hd_reg;
    logic signed [30:0]   m_dx_reg;
    logic signed [30:0]   m_dy_reg;
    logic signed [NW-1:0] m_num_reg;
    logic signed [DW-1:0] m_den_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_px_reg  <= c_pose.px;
            m_py_reg  <= c_pose.py;
            m_hd_reg  <= c_pose.hd;
            m_dx_reg  <= dx_prod[NW-1:30];
            m_dy_reg  <= dy_prod[NW-1:30];
            m_num_reg <= num_prod;
            m_den_reg <= den_prod[DW+FB-1:FB];
        end
    end

    // stage P: position sums, divider setup
    logic [PW:0]          x_sat;
    logic [PW:0]          y_sat;
    logic [NW-1:0]        num_mag;
    logic [DW-1:0]        den_mag;
    logic                 ovf_next;
    bks_pkg::div_side_t   p_side_next;

    assign x_sat   = bks_pkg::sat32(XW'(m_px_reg) + XW'(m_dx_reg));
    assign y_sat   = bks_pkg::sat32(XW'(m_py_reg) + XW'(m_dy_reg));
    assign num_mag = m_num_reg[NW-1] ? NW'(-m_num_reg) : NW'(m_num_reg);
    assign den_mag = m_den_reg[DW-1] ? DW'(-m_den_reg) : DW'(m_den_reg);
    assign ovf_next = (m_num_reg != '0)
                   && (bks_pkg::CMP_W'(num_mag) >= {den_mag, {QW{1'b0}}});

    always_comb
    begin
        p_side_next.nx  = x_sat[PW-1:0];
        p_side_next.ny  = y_sat[PW-1:0];
        p_side_next.hd  = m_hd_reg;
        p_side_next.sat = x_sat[PW] | y_sat[PW];
        p_side_next.neg = m_num_reg[NW-1] ^ m_den_reg[DW-1];
        p_side_next.ovf = ovf_next;
    end

    logic                 p_vld_reg;
    logic [NW-1:0]        p_num_reg;
    logic [DW-1:0]        p_den_reg;
    bks_pkg::div_side_t   p_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_num_reg  <= num_mag;
            p_den_reg  <= den_mag;
            p_side_reg <= p_side_next;
        end
    end

    logic                 d_vld;
    logic [QW-1:0]        d_quo;
    bks_pkg::div_side_t   d_side;

    bks_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_vld_reg),
        .num_mag   (p_num_reg),
        .den_mag   (p_den_reg),
        .side_in   (p_side_reg),
        .out_valid (d_vld),
        .quo       (d_quo),
        .side_out  (d_side)
    );

    // final stage: heading update into the output register
    logic [QW:0]                         q_mag;
    logic signed [bks_pkg::DYAW_W-1:0]   dyaw;
    logic [PW:0]                         h_sat;
    logic [bks_pkg::OUT_TDATA_W-1:0]     tdata_next;
    logic [bks_pkg::OUT_TDATA_W-1:0]     out_data_reg;
    logic                                out_sat_reg;

    assign q_mag      = d_side.ovf ? {1'b1, {QW{1'b0}}} : {1'b0, d_quo};
    assign dyaw       = d_side.neg ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});
    assign h_sat      = bks_pkg::sat32(XW'(d_side.hd) + XW'(dyaw));
    assign tdata_next = {h_sat[PW-1:0], d_side.ny, d_side.nx};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= tdata_next;
            out_sat_reg  <= d_side.sat | h_sat[PW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            m_vld_reg   <= c_vld;
            p_vld_reg   <= m_vld_reg;
            out_vld_reg <= d_vld;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule

`default_nettype wire

[rtl/core/bks_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module bks_cordic #(
    parameter int STEPS = 16
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      adv,
    input  wire                                      in_valid,
    input  wire  [bks_pkg::PHASE_W-1:0]              phase_a,
    input  wire  [bks_pkg::PHASE_W-1:0]              phase_b,
    input  bks_pkg::pose_t                           side_in,
    output logic                                     out_valid,
    output logic signed [bks_pkg::CORDIC_W-1:0]      cos_a,
    output logic signed [bks_pkg::CORDIC_W-1:0]      sin_a,
    output logic signed [bks_pkg::CORDIC_W-1:0]      cos_b,
    output logic signed [bks_pkg::CORDIC_W-1:0]      sin_b,
    output bks_pkg::pose_t                           side_out
);

    localparam int W = bks_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg    [0:STEPS][0:1];
    logic signed [W-1:0] y_reg    [0:STEPS][0:1];
    logic signed [W-1:0] z_reg    [0:STEPS][0:1];
    logic                flip_reg [0:STEPS][0:1];
    bks_pkg::pose_t      side_reg [0:STEPS];
    logic                vld_reg  [0:STEPS+1];
    logic signed [W-1:0] cos_reg  [0:1];
    logic signed [W-1:0] sin_reg  [0:1];
    bks_pkg::pose_t      side_out_reg;
    logic [bks_pkg::PHASE_W-1:0] phase [0:1];

    assign phase[0] = phase_a;
    assign phase[1] = phase_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS + 1; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= STEPS + 1; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k <= STEPS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            side_out_reg <= side_reg[STEPS];
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic          flip_next;
        logic          top_bit;
        logic [W-1:0]  z_next;

        // fold the left half-plane onto the right
        assign flip_next = phase[l][31] ^ phase[l][30];
        assign top_bit   = phase[l][31] ^ flip_next;
        assign z_next    = {top_bit, top_bit, phase[l][30:0]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[0][l]    <= bks_pkg::CORDIC_GAIN;
                y_reg[0][l]    <= '0;
                z_reg[0][l]    <= signed'(z_next);
                flip_reg[0][l] <= flip_next;
            end
        end

        for (genvar k = 1; k <= STEPS; k++)
        begin : g_step
            logic signed [W-1:0] xs;
            logic signed [W-1:0] ys;
            logic signed [W-1:0] ang;
            logic signed [W-1:0] x_next;
            logic signed [W-1:0] y_next;
            logic signed [W-1:0] z_next_s;

            assign xs  = x_reg[k-1][l] >>> (k - 1);
            assign ys  = y_reg[k-1][l] >>> (k - 1);
            assign ang = signed'({3'b000, bks_pkg::atan_phase(k - 1)});

            always_comb
            begin
                if (!z_reg[k-1][l][W-1])
                begin
                    x_next   = x_reg[k-1][l] - ys;
                    y_next   = y_reg[k-1][l] + xs;
                    z_next_s = z_reg[k-1][l] - ang;
                end
                else
                begin
                    x_next   = x_reg[k-1][l] + ys;
                    y_next   = y_reg[k-1][l] - xs;
                    z_next_s = z_reg[k-1][l] + ang;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[k][l]    <= x_next;
                    y_reg[k][l]    <= y_next;
                    z_reg[k][l]    <= z_next_s;
                    flip_reg[k][l] <= flip_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cos_reg[l] <= flip_reg[STEPS][l] ? -x_reg[STEPS][l] : x_reg[STEPS][l];
                sin_reg[l] <= flip_reg[STEPS][l] ? -y_reg[STEPS][l] : y_reg[STEPS][l];
            end
        end
    end

    assign out_valid = vld_reg[STEPS+1];
    assign cos_a     = cos_reg[0];
    assign sin_a     = sin_reg[0];
    assign cos_b     = cos_reg[1];
    assign sin_b     = sin_reg[1];
    assign side_out  = side_out_reg;

endmodule

`default_nettype wire

[rtl/core/bks_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module bks_div (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               adv,
    input  wire                               in_valid,
    input  wire  [bks_pkg::NUM_W-1:0]         num_mag,
    input  wire  [bks_pkg::DEN_W-1:0]         den_mag,
    input  bks_pkg::div_side_t                side_in,
    output logic                              out_valid,
    output logic [bks_pkg::QUO_W-1:0]         quo,
    output bks_pkg::div_side_t                side_out
);

    localparam int QW = bks_pkg::QUO_W;
    localparam int NW = bks_pkg::NUM_W;
    localparam int DW = bks_pkg::DEN_W;
    localparam int CW = bks_pkg::CMP_W;

    logic [NW-1:0]      rem_reg  [0:QW-1];
    logic [DW-1:0]      den_reg  [0:QW-1];
    logic [QW-1:0]      quo_reg  [0:QW-1];
    bks_pkg::div_side_t side_reg [0:QW-1];
    logic               vld_reg  [0:QW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < QW; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] trial;
        logic          take;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num_mag;
            assign den_in = den_mag;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // a zero divisor yields a zero quotient
        assign trial    = CW'(den_in) << (QW - 1 - k);
        assign take     = (den_in != '0) && (CW'(rem_in) >= trial);
        assign rem_next = take ? (rem_in - trial[NW-1:0]) : rem_in;

        always_comb
        begin
            quo_next = quo_in;
            quo_next[QW-1-k] = take;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

[rtl/core/bks_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bks_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_axis_tready,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [bks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire                               m_axis_tuser
);

    logic x_edge;
    logic y_edge;
    logic h_edge;

    assign x_edge = (m_axis_tdata[31:0] == 32'h7FFF_FFFF)
                 || (m_axis_tdata[31:0] == 32'h8000_0000);
    assign y_edge = (m_axis_tdata[63:32] == 32'h7FFF_FFFF)
                 || (m_axis_tdata[63:32] == 32'h8000_0000);
    assign h_edge = (m_axis_tdata[95:64] == 32'h7FFF_FFFF)
                 || (m_axis_tdata[95:64] == 32'h8000_0000);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (x_edge || y_edge || h_edge))
        else $error("saturated flag without a clipped field");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output item changed while stalled");

endmodule

bind bicycle_kinematic_step_core bks_checker u_bks_checker (.*);

`default_nettype wire
